@@ rtl/wrbt_pkg.sv @@
package wrbt_pkg;

  localparam int unsigned ValW  = 16;
  localparam int unsigned ActW  = 3;
  localparam int unsigned ModeW = 2;
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 40;

  localparam logic [ValW-1:0] ValMax = {ValW{1'b1}};

  // action codes
  localparam logic [ActW-1:0] ACT_TICK     = 3'd0;
  localparam logic [ActW-1:0] ACT_START    = 3'd1;
  localparam logic [ActW-1:0] ACT_PAUSE    = 3'd2;
  localparam logic [ActW-1:0] ACT_CONTINUE = 3'd3;
  localparam logic [ActW-1:0] ACT_DELAY    = 3'd4;
  localparam logic [ActW-1:0] ACT_REST_NOW = 3'd5;

  // modes
  localparam logic [ModeW-1:0] MODE_INIT   = 2'd0;
  localparam logic [ModeW-1:0] MODE_ACTIVE = 2'd1;
  localparam logic [ModeW-1:0] MODE_IDLE   = 2'd2;
  localparam logic [ModeW-1:0] MODE_LOCK   = 2'd3;

  // register indexes
  localparam logic [1:0] REG_WORK_INTERVAL = 2'd0;
  localparam logic [1:0] REG_IDLE_LIMIT    = 2'd1;
  localparam logic [1:0] REG_REST_LENGTH   = 2'd2;

  localparam logic [ValW-1:0] WorkIntervalRst = 16'd2700;
  localparam logic [ValW-1:0] IdleLimitRst    = 16'd300;
  localparam logic [ValW-1:0] RestLengthRst   = 16'd180;

  typedef struct packed {
    logic [ValW-1:0] work_interval;
    logic [ValW-1:0] idle_limit;
    logic [ValW-1:0] rest_length;
  } cfg_t;

  typedef struct packed {
    logic [ActW-1:0] action;
    logic [ValW-1:0] amount;
    logic            user_input_seen;
    logic            fullscreen_active;
  } item_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             paused;
    logic [ValW-1:0]  work_left;
    logic [ValW-1:0]  rest_left;
    logic             lock_pulse;
    logic             unlock_pulse;
  } result_t;

  function automatic logic [ValW-1:0] sat_add(input logic [ValW-1:0] a,
                                              input logic [ValW-1:0] b);
    logic [ValW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ValW] ? ValMax : s[ValW-1:0];
  endfunction

  function automatic logic [ValW-1:0] sat_sub(input logic [ValW-1:0] a,
                                              input logic [ValW-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

endpackage

@@ rtl/wrbt_cfg.sv @@
module wrbt_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [wrbt_pkg::CfgAddrW-1:0]   addr,
  input  logic [wrbt_pkg::CfgDataW-1:0]   wdata,
  output logic [wrbt_pkg::CfgDataW-1:0]   rdata,
  output wrbt_pkg::cfg_t                  cfg
);
  import wrbt_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic [1:0] idx;

  assign idx = addr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_WORK_INTERVAL: cfg_nxt.work_interval = wdata[ValW-1:0];
        REG_IDLE_LIMIT:    cfg_nxt.idle_limit    = wdata[ValW-1:0];
        REG_REST_LENGTH:   cfg_nxt.rest_length   = wdata[ValW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.work_interval <= WorkIntervalRst;
      cfg_r.idle_limit    <= IdleLimitRst;
      cfg_r.rest_length   <= RestLengthRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_WORK_INTERVAL: rdata = {{(CfgDataW-ValW){1'b0}}, cfg_r.work_interval};
      REG_IDLE_LIMIT:    rdata = {{(CfgDataW-ValW){1'b0}}, cfg_r.idle_limit};
      REG_REST_LENGTH:   rdata = {{(CfgDataW-ValW){1'b0}}, cfg_r.rest_length};
      default:           rdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/wrbt_core.sv @@
module wrbt_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  wrbt_pkg::item_t     item,
  input  wrbt_pkg::cfg_t      cfg,
  output wrbt_pkg::result_t   res
);
  import wrbt_pkg::*;

  logic [ModeW-1:0] mode_r, mode_nxt;
  logic             pause_r, pause_nxt;
  logic [ValW-1:0]  work_r, work_nxt;
  logic [ValW-1:0]  idle_r, idle_nxt;
  logic [ValW-1:0]  rest_r, rest_nxt;
  logic             lock_p, unlock_p;
  logic [ValW-1:0]  idle_upd;
  logic [ValW-1:0]  rest_upd;

  assign idle_upd = item.user_input_seen ? '0 : sat_add(idle_r, item.amount);
  assign rest_upd = sat_add(rest_r, item.amount);

  always_comb begin
    mode_nxt  = mode_r;
    pause_nxt = pause_r;
    work_nxt  = work_r;
    idle_nxt  = idle_r;
    rest_nxt  = rest_r;
    lock_p    = 1'b0;
    unlock_p  = 1'b0;
    case (item.action)
      ACT_TICK: begin
        case (mode_r)
          MODE_ACTIVE: begin
            if (work_r == '0) begin
              // out of work time: lock, nothing else this step
              mode_nxt = MODE_LOCK;
              rest_nxt = '0;
              lock_p   = 1'b1;
            end else begin
              if (!pause_r && !item.fullscreen_active) begin
                work_nxt = sat_sub(work_r, item.amount);
              end
              idle_nxt = idle_upd;
              if (idle_upd >= cfg.idle_limit) begin
                mode_nxt = MODE_IDLE;
              end
            end
          end
          MODE_IDLE: begin
            if (item.user_input_seen) begin
              mode_nxt = MODE_ACTIVE;
              work_nxt = cfg.work_interval;
            end
          end
          MODE_LOCK: begin
            rest_nxt = rest_upd;
            if (rest_upd >= cfg.rest_length) begin
              mode_nxt = MODE_ACTIVE;
              work_nxt = cfg.work_interval;
              unlock_p = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ACT_START: begin
        mode_nxt = MODE_ACTIVE;
        work_nxt = cfg.work_interval;
        unlock_p = (mode_r == MODE_LOCK);
      end
      ACT_PAUSE:    pause_nxt = 1'b1;
      ACT_CONTINUE: pause_nxt = 1'b0;
      ACT_DELAY:    work_nxt  = sat_add(work_r, item.amount);
      ACT_REST_NOW: work_nxt  = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_INIT;
      pause_r <= 1'b0;
      work_r  <= '0;
      idle_r  <= '0;
      rest_r  <= '0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      pause_r <= pause_nxt;
      work_r  <= work_nxt;
      idle_r  <= idle_nxt;
      rest_r  <= rest_nxt;
    end
  end

  always_comb begin
    res.mode         = mode_nxt;
    res.paused       = pause_nxt;
    res.work_left    = work_nxt;
    res.rest_left    = sat_sub(cfg.rest_length, rest_nxt);
    res.lock_pulse   = lock_p;
    res.unlock_pulse = unlock_p;
  end

endmodule

@@ rtl/work_rest_break_timer.sv @@
// Channel  Dir  Handshake              Payload
// in_      in   in_tvalid/in_tready    tdata: amount, user_input_seen, fullscreen_active
//                                      tuser: action
// out_     out  out_tvalid/out_tready  tdata: mode, paused, work_left, rest_left,
//                                             lock_pulse, unlock_pulse
// cfg_     in   APB write/read         work_interval @0, idle_limit @4, rest_length @8
//
// Two register stages: input register, then one pass of step logic that
// updates the timer state and loads the result register. One item per cycle
// while out_ is not stalled; an item's result is offered on out_ once the
// step logic has loaded it from the input register into the result register.
// Reset (rst_n low, synchronous) empties both stages, sets init mode with
// cleared counters and loads the default register values.
// A stalled output holds the result register and the input register; the
// input side keeps taking items while the input register is free.
module work_rest_break_timer (
  input  logic                               clk,
  input  logic                               rst_n,
  // item in
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [15:0] amount, [16] user_input_seen, [17] fullscreen_active, [23:18] zero
  input  logic [wrbt_pkg::InDataW-1:0]       in_tdata,
  // [2:0] action
  input  logic [wrbt_pkg::ActW-1:0]          in_tuser,
  // result out
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [1:0] mode, [2] paused, [18:3] work_left, [34:19] rest_left,
  // [35] lock_pulse, [36] unlock_pulse, [39:37] zero
  output logic [wrbt_pkg::OutDataW-1:0]      out_tdata,
  // configuration
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [wrbt_pkg::CfgAddrW-1:0]      cfg_paddr,
  input  logic [wrbt_pkg::CfgDataW-1:0]      cfg_pwdata,
  output logic [wrbt_pkg::CfgDataW-1:0]      cfg_prdata,
  output logic                               cfg_pready
);
  import wrbt_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    item_vld_r;
  result_t res;
  result_t res_r;
  logic    res_vld_r;
  logic    out_free;   // result register can take a new result
  logic    step;       // item in the input register is processed this cycle
  logic    in_fire;

  assign cfg_pready = 1'b1;

  wrbt_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (cfg_psel & cfg_penable & cfg_pwrite),
    .addr  (cfg_paddr),
    .wdata (cfg_pwdata),
    .rdata (cfg_prdata),
    .cfg   (cfg)
  );

  assign out_free  = !res_vld_r || out_tready;
  assign step      = item_vld_r && out_free;
  assign in_tready = !item_vld_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.action            <= in_tuser;
      item_r.amount            <= in_tdata[ValW-1:0];
      item_r.user_input_seen   <= in_tdata[ValW];
      item_r.fullscreen_active <= in_tdata[ValW+1];
    end
  end

  wrbt_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (out_free) begin
      res_vld_r <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = res_vld_r;
  assign out_tdata  = {3'b000, res_r.unlock_pulse, res_r.lock_pulse, res_r.rest_left,
                       res_r.work_left, res_r.paused, res_r.mode};

endmodule
